/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the triac phase timer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define TPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg
// Types, widths and constants shared by the triac phase delay firing block.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int BYTE_W     = 8;
    localparam int DELAY_W    = 9;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_BYTE       = 2'd0,
        REQ_TICK       = 2'd1,
        REQ_ZERO_CROSS = 2'd2
    } tpd_req_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_LIMIT   = 1'd0,
        CFG_PRESET_DELAY = 1'd1
    } tpd_cfg_e;

    localparam logic [DELAY_W-1:0] TICK_LIMIT_RST   = 9'd410;
    localparam logic [DELAY_W-1:0] PRESET_DELAY_RST = 9'd150;

    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_D    = 8'h64;
    localparam logic [BYTE_W-1:0] CH_X    = 8'h78;

    // Outcome of decoding one received byte.
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic               gate_off;
    } tpd_dec_t;

    // Outcome of one timer tick.
    typedef struct packed {
        logic [DELAY_W-1:0] count;
        logic               gate;
    } tpd_tick_t;

endpackage

/* rtl/core/tpd_req_if.sv */
// ----------------------------------------------------------------------------
// tpd_req_if
// Request channel: serial byte, timer tick or zero-cross event.
// ----------------------------------------------------------------------------
interface tpd_req_if
    import tpd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BYTE_W-1:0]     rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

/* rtl/core/tpd_res_if.sv */
// ----------------------------------------------------------------------------
// tpd_res_if
// Result channel: gate drive level and current firing delay.
// ----------------------------------------------------------------------------
interface tpd_res_if
    import tpd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               gate_on;
    logic [DELAY_W-1:0] firing_delay;

    modport source (output valid, output gate_on, output firing_delay, input ready);
    modport sink   (input valid, input gate_on, input firing_delay, output ready);
endinterface

/* rtl/core/tpd_byte_decoder.sv */
// ----------------------------------------------------------------------------
// tpd_byte_decoder
// Decodes the two-byte history into a command letter or a two-digit delay.
// ----------------------------------------------------------------------------
module tpd_byte_decoder
    import tpd_pkg::*;
(
    input  logic [BYTE_W-1:0]  new_byte,
    input  logic [BYTE_W-1:0]  old_byte,
    input  logic [DELAY_W-1:0] preset_delay,
    output tpd_dec_t           dec
);

    logic       is_cmd;
    logic       ones_ok;
    logic       tens_ok;
    logic [3:0] ones;
    logic [3:0] tens;

    always_comb
    begin
        is_cmd  = (new_byte > CH_NINE) || (old_byte > CH_NINE);
        // Both bytes are at most '9' here, so only the lower bound matters.
        ones_ok = (new_byte >= CH_ZERO);
        tens_ok = (old_byte >= CH_ZERO);
        ones    = ones_ok ? 4'(new_byte - CH_ZERO) : 4'd0;
        tens    = tens_ok ? 4'(old_byte - CH_ZERO) : 4'd0;

        if (is_cmd)
        begin
            unique case (new_byte)
                CH_A:
                begin
                    dec.delay    = DELAY_W'(1);
                    dec.gate_off = 1'b0;
                end
                CH_D:
                begin
                    dec.delay    = preset_delay;
                    dec.gate_off = 1'b0;
                end
                default:
                begin
                    // Every byte other than 'a' or 'd', 'x' included, stops the firing.
                    dec.delay    = '0;
                    dec.gate_off = 1'b1;
                end
            endcase
        end
        else
        begin
            dec.delay    = DELAY_W'(tens) * DELAY_W'(30) + DELAY_W'(ones) * DELAY_W'(3);
            dec.gate_off = !(ones_ok && tens_ok);
        end
    end

endmodule

/* rtl/core/tpd_phase_timer.sv */
// ----------------------------------------------------------------------------
// tpd_phase_timer
// Phase counter step on a timer tick: gate level and wrap at the tick limit.
// ----------------------------------------------------------------------------
module tpd_phase_timer
    import tpd_pkg::*;
(
    input  logic [DELAY_W-1:0] count,
    input  logic [DELAY_W-1:0] delay,
    input  logic [DELAY_W-1:0] tick_limit,
    input  logic               gate,
    output tpd_tick_t          tick
);

    always_comb
    begin
        tick.count = count;
        tick.gate  = gate;
        // A zero delay disables the timer altogether.
        if (delay != '0)
        begin
            if (count == tick_limit)
            begin
                tick.gate  = 1'b0;
                tick.count = '0;
            end
            else
            begin
                tick.gate  = (count > delay);
                tick.count = count + DELAY_W'(1);
            end
        end
    end

endmodule

/* rtl/core/triac_phase_delay_firing.sv */
// Result: registered; an accepted request's result is valid in the next cycle.
// Throughput: one request per cycle; the request side stays ready while the
// result register is empty or being drained in the same cycle.
// Reset: tick limit 410, preset delay 150, byte history 'a','a', delay,
// phase count and gate all zero; no result pending.
// ----------------------------------------------------------------------------
// triac_phase_delay_firing
// Phase-angle triac gate timer with a serial command decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triac_phase_delay_firing
    import tpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tpd_req_if.sink              req,
    tpd_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_wdata
);

    logic [DELAY_W-1:0] tick_limit_reg;
    logic [DELAY_W-1:0] preset_delay_reg;
    logic [BYTE_W-1:0]  last_byte_reg;
    logic [BYTE_W-1:0]  last_byte_next;
    logic [BYTE_W-1:0]  prev_byte_reg;
    logic [BYTE_W-1:0]  prev_byte_next;
    logic [DELAY_W-1:0] delay_ticks_reg;
    logic [DELAY_W-1:0] delay_ticks_next;
    logic [DELAY_W-1:0] phase_count_reg;
    logic [DELAY_W-1:0] phase_count_next;
    logic               gate_level_reg;
    logic               gate_level_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic               req_fire;

    tpd_dec_t  dec;
    tpd_tick_t tick;

    tpd_byte_decoder u_decoder (
        .new_byte     (req.rx_byte),
        .old_byte     (last_byte_reg),
        .preset_delay (preset_delay_reg),
        .dec          (dec)
    );

    tpd_phase_timer u_timer (
        .count      (phase_count_reg),
        .delay      (delay_ticks_reg),
        .tick_limit (tick_limit_reg),
        .gate       (gate_level_reg),
        .tick       (tick)
    );

    assign req.ready = !res_valid_reg || res.ready;
    assign req_fire  = req.valid && req.ready;

    // The state after an item is its result, so the state registers drive the
    // result payload; they only move when the result slot is free.
    assign res.valid        = res_valid_reg;
    assign res.gate_on      = gate_level_reg;
    assign res.firing_delay = delay_ticks_reg;

    always_comb
    begin
        last_byte_next   = last_byte_reg;
        prev_byte_next   = prev_byte_reg;
        delay_ticks_next = delay_ticks_reg;
        phase_count_next = phase_count_reg;
        gate_level_next  = gate_level_reg;
        res_valid_next   = res_valid_reg && !res.ready;

        if (req_fire)
        begin
            res_valid_next = 1'b1;
            unique case (req.req_type)
                REQ_BYTE:
                begin
                    prev_byte_next   = last_byte_reg;
                    last_byte_next   = req.rx_byte;
                    delay_ticks_next = dec.delay;
                    if (dec.gate_off)
                    begin
                        gate_level_next = 1'b0;
                    end
                end
                REQ_TICK:
                begin
                    phase_count_next = tick.count;
                    gate_level_next  = tick.gate;
                end
                REQ_ZERO_CROSS:
                begin
                    phase_count_next = '0;
                end
                default:
                begin
                    // Unused request code: report the state unchanged.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg   <= CH_A;
            prev_byte_reg   <= CH_A;
            delay_ticks_reg <= '0;
            phase_count_reg <= '0;
            gate_level_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            last_byte_reg   <= last_byte_next;
            prev_byte_reg   <= prev_byte_next;
            delay_ticks_reg <= delay_ticks_next;
            phase_count_reg <= phase_count_next;
            gate_level_reg  <= gate_level_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg   <= TICK_LIMIT_RST;
            preset_delay_reg <= PRESET_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TICK_LIMIT:   tick_limit_reg   <= cfg_wdata;
                CFG_PRESET_DELAY: preset_delay_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    `TPD_ASSERT(a_zero_cross_clears, (req_fire && req.req_type == REQ_ZERO_CROSS) |=> (phase_count_reg == '0), "zero-cross did not clear the phase counter")

    `TPD_ASSERT(a_byte_history, (req_fire && req.req_type == REQ_BYTE) |=> (prev_byte_reg == $past(last_byte_reg)), "byte history did not shift")

    `TPD_ASSERT(a_limit_wrap, (req_fire && req.req_type == REQ_TICK && delay_ticks_reg != '0 && phase_count_reg == tick_limit_reg) |=> (!gate_level_reg && phase_count_reg == '0), "counter at the limit did not cut the gate and restart")

    `TPD_ASSERT(a_no_overrun, (res_valid_reg && !res.ready) |-> !req.ready, "request taken while a result is still held")

endmodule
